### design/chs_lba_translator_core_defines.svh
// Assertion macros for the CHS/LBA translator core.
`ifndef CHS_LBA_TRANSLATOR_CORE_DEFINES_SVH
`define CHS_LBA_TRANSLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is held.
`define CHS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define CHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CHS_ASSERT(lbl, clk, rstn, prop, msg)
`define CHS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### design/chs_lba_pkg.sv
// Shared widths, register codes and pipeline item types for the CHS/LBA translator.
`timescale 1ns / 1ps

package chs_lba_pkg;

    localparam int LBA_W  = 32;
    localparam int CYL_W  = 16;
    localparam int GEO_W  = 8;
    localparam int ACC_W  = 24;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register select, taken from address bit 2
    localparam logic REG_HPC = 1'b0;
    localparam logic REG_SPT = 1'b1;

    // One item as it moves through the divider stages
    typedef struct packed {
        logic             mode;
        logic [LBA_W-1:0] work;      // dividend shifting out, quotient shifting in
        logic [GEO_W-1:0] rem;       // running remainder
        logic [GEO_W-1:0] sect_rem;  // remainder of the first division
        logic [LBA_W-1:0] lba_res;   // mode 1 address
        logic [CYL_W-1:0] cyl;
        logic [GEO_W-1:0] head;
        logic [GEO_W-1:0] sect;
    } t_stage;

    // One result item in the output register
    typedef struct packed {
        logic             mode;
        logic [GEO_W-1:0] sect;
        logic [GEO_W-1:0] head;
        logic [CYL_W-1:0] cyl;
        logic [LBA_W-1:0] lba;
    } t_result;

endpackage

### design/chs_lba_div_step.sv
// Restoring division steps by an 8-bit divisor, STEPS quotient bits per pipeline stage.
`timescale 1ns / 1ps

module chs_lba_div_step
    import chs_lba_pkg::*;
#(
    parameter int STEPS = 4
) (
    input  logic [LBA_W-1:0] i_work,
    input  logic [GEO_W-1:0] i_rem,
    input  logic [GEO_W-1:0] i_divisor,
    output logic [LBA_W-1:0] o_work,
    output logic [GEO_W-1:0] o_rem
);

    logic [LBA_W-1:0] c_work;
    logic [GEO_W-1:0] c_rem;
    logic [GEO_W:0]   c_trial;

    // Shift one dividend bit into the remainder, subtract where it fits
    always_comb begin
        c_work  = i_work;
        c_rem   = i_rem;
        c_trial = '0;
        for (int s = 0; s < STEPS; s++) begin
            c_trial = {c_rem, c_work[LBA_W-1]};
            c_work  = {c_work[LBA_W-2:0], 1'b0};
            if (c_trial >= {1'b0, i_divisor}) begin
                c_rem     = GEO_W'(c_trial - {1'b0, i_divisor});
                c_work[0] = 1'b1;
            end else begin
                c_rem = c_trial[GEO_W-1:0];
            end
        end
    end

    assign o_work = c_work;
    assign o_rem  = c_rem;

endmodule

### design/chs_lba_pipe_ctrl.sv
// Valid bits and per-stage load enables for the translator pipeline, bubbles collapse.
`timescale 1ns / 1ps

module chs_lba_pipe_ctrl #(
    parameter int DEPTH = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic [DEPTH-1:0] o_load,
    output logic [DEPTH-1:0] o_valid
);

    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    logic [DEPTH-1:0] w_load;

    // A stage loads when it is empty or its item moves on
    always_comb begin
        w_load[DEPTH-1] = !r_valid[DEPTH-1] || i_out_ready;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    // Advance valid bits on load, hold otherwise
    always_comb begin
        n_valid[0] = w_load[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < DEPTH; k++) begin
            n_valid[k] = w_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready = w_load[0];
    assign o_load     = w_load;
    assign o_valid    = r_valid;

endmodule

### design/chs_lba_translator_core.sv
// Top level of the CHS/LBA translator: config registers, stage datapath, output register.
//
//  channel   | direction | handshake                   | contents
//  ----------+-----------+-----------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata lba,cyl,head,sect; tuser mode
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata lba,cyl,head,sect
//  apb       | in/out    | psel/penable, pready high   | heads per cylinder, sectors per track
//
//  An item is accepted every cycle while the output is not stalled; items pass through
//  the two chained dividers (LBA by sectors, then by heads) at STEP_BITS quotient
//  bits per stage, then the output register.
//  Mode 1 multiplies run in the second and third divider stages and ride along.
//  Reset is synchronous, active low; it clears valid bits and restores geometry 16/63.
//  A stall holds only the full stages in front of it; empty stages keep filling.
`timescale 1ns / 1ps
`include "chs_lba_translator_core_defines.svh"

module chs_lba_translator_core
    import chs_lba_pkg::*;
#(
    parameter int STEP_BITS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // lba_in[31:0], cylinder_in, head_in, sector_in
    input  logic              s_axis_tuser,   // mode
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // lba_out[31:0], cylinder_out, head_out, sector_out
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int DIV_STAGES = LBA_W / STEP_BITS;
    localparam int NSTG       = 2 * DIV_STAGES;
    localparam int DEPTH      = NSTG + 1;

    logic [GEO_W-1:0] r_hpc;
    logic [GEO_W-1:0] r_spt;
    logic [DEPTH-1:0] w_load;
    logic [DEPTH-1:0] w_valid;
    t_stage           r_stg [NSTG];
    t_result          r_out;
    t_result          n_out;

    // Write geometry registers in the APB access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpc <= GEO_W'(16);
            r_spt <= GEO_W'(63);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_HPC: r_hpc <= pwdata[GEO_W-1:0];
                REG_SPT: r_spt <= pwdata[GEO_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back geometry
    always_comb begin
        unique case (paddr[2])
            REG_HPC: prdata = {{(DATA_W-GEO_W){1'b0}}, r_hpc};
            REG_SPT: prdata = {{(DATA_W-GEO_W){1'b0}}, r_spt};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    chs_lba_pipe_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_load      (w_load),
        .o_valid     (w_valid)
    );

    // Divider stages: first LBA by sectors per track, then the quotient by heads
    for (genvar j = 0; j < NSTG; j++) begin : g_stage
        t_stage           w_src;
        t_stage           w_nxt;
        logic [LBA_W-1:0] w_work;
        logic [GEO_W-1:0] w_rem;
        logic [GEO_W-1:0] w_div;

        if (j == 0) begin : g_src_in
            // Unpack the input item
            always_comb begin
                w_src          = '0;
                w_src.mode     = s_axis_tuser;
                w_src.work     = s_axis_tdata[31:0];
                w_src.cyl      = s_axis_tdata[47:32];
                w_src.head     = s_axis_tdata[55:48];
                w_src.sect     = s_axis_tdata[63:56];
            end
        end else if (j == DIV_STAGES) begin : g_src_mid
            // Keep the sector remainder, restart with the track quotient
            always_comb begin
                w_src          = r_stg[j-1];
                w_src.sect_rem = r_stg[j-1].rem;
                w_src.rem      = '0;
            end
        end else begin : g_src_chain
            assign w_src = r_stg[j-1];
        end

        assign w_div = (j < DIV_STAGES) ? r_spt : r_hpc;

        chs_lba_div_step #(
            .STEPS (STEP_BITS)
        ) u_step (
            .i_work    (w_src.work),
            .i_rem     (w_src.rem),
            .i_divisor (w_div),
            .o_work    (w_work),
            .o_rem     (w_rem)
        );

        // Mode 1 address: C*heads + H, then times sectors plus S - 1
        always_comb begin
            w_nxt      = w_src;
            w_nxt.work = w_work;
            w_nxt.rem  = w_rem;
            if (j == 1) begin
                w_nxt.lba_res = {{(LBA_W-ACC_W){1'b0}},
                                 ACC_W'(ACC_W'(w_src.cyl) * ACC_W'(r_hpc))
                                 + ACC_W'(w_src.head)};
            end
            if (j == 2) begin
                w_nxt.lba_res = LBA_W'(w_src.lba_res * LBA_W'(r_spt))
                                + LBA_W'(w_src.sect) - LBA_W'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_load[j]) begin
                r_stg[j] <= w_nxt;
            end
        end
    end

    // Format the result, zero unused fields and zero geometry
    always_comb begin
        n_out      = '0;
        n_out.mode = r_stg[NSTG-1].mode;
        if (r_hpc != '0 && r_spt != '0) begin
            if (!r_stg[NSTG-1].mode) begin
                n_out.cyl  = r_stg[NSTG-1].work[CYL_W-1:0];
                n_out.head = r_stg[NSTG-1].rem;
                n_out.sect = r_stg[NSTG-1].sect_rem + GEO_W'(1);
            end else begin
                n_out.lba  = r_stg[NSTG-1].lba_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[DEPTH-1]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = w_valid[DEPTH-1];
    assign m_axis_tdata  = {r_out.sect, r_out.head, r_out.cyl, r_out.lba};

    // An empty output register means every stage can load
    `CHS_ASSERT(a_ready_when_out_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    // Fields of the other mode are zero
    `CHS_ASSERT(a_unused_zero, i_clk, i_rst_n, m_axis_tvalid |-> (r_out.mode ? (m_axis_tdata[63:32] == '0) : (m_axis_tdata[31:0] == '0)), "unused result field not zero")
    // Reset empties the pipeline
    `CHS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the CHS/LBA translator core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top
    import chs_lba_pkg::*;
();

    localparam logic MODE_LBA2CHS = 1'b0;
    localparam logic MODE_CHS2LBA = 1'b1;
    localparam logic [ADDR_W-1:0] HPC_ADDR = {REG_HPC, 2'b00};
    localparam logic [ADDR_W-1:0] SPT_ADDR = {REG_SPT, 2'b00};
    localparam logic [GEO_W-1:0] RESET_HPC = 8'd16;
    localparam logic [GEO_W-1:0] RESET_SPT = 8'd63;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 135;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 500000;

    // Same layout as tdata on both sides: lba, cylinder, head, sector from bit 0 up
    typedef struct packed {
        logic [GEO_W-1:0] sect;
        logic [GEO_W-1:0] head;
        logic [CYL_W-1:0] cyl;
        logic [LBA_W-1:0] lba;
    } t_chs_addr;

    localparam t_chs_addr ALL_ZERO = '0;

    typedef struct {
        logic [GEO_W-1:0] hpc;
        logic [GEO_W-1:0] spt;
        logic             mode;
        t_chs_addr        addr;
        bit               typed;
        t_chs_addr        want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;   // lba_in, cylinder_in, head_in, sector_in
    logic              s_axis_tuser;   // mode
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;   // lba_out, cylinder_out, head_out, sector_out
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_chs_addr        expected_addrs[$];
    t_row             directed_rows[$];
    logic [GEO_W-1:0] geo_hpc;
    logic [GEO_W-1:0] geo_spt;
    bit               quiet_run = 1'b0;
    int               mismatches = 0;
    int               results_checked = 0;
    int               items_sent = 0;
    int               geometries = 1;

    chs_lba_translator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Compute the translated address for one item under the given geometry
    function automatic t_chs_addr translate_addr(input logic mode, input t_chs_addr src,
                                                 input logic [GEO_W-1:0] hpc,
                                                 input logic [GEO_W-1:0] spt);
        t_chs_addr        res;
        logic [LBA_W-1:0] hpc_w;
        logic [LBA_W-1:0] spt_w;
        logic [LBA_W-1:0] quot;
        logic [LBA_W-1:0] acc;
        res   = '0;
        hpc_w = LBA_W'(hpc);
        spt_w = LBA_W'(spt);
        if (hpc_w == 0 || spt_w == 0) begin
            return res;
        end
        if (mode == MODE_LBA2CHS) begin
            quot     = src.lba / (hpc_w * spt_w);
            res.cyl  = quot[CYL_W-1:0];
            quot     = (src.lba / spt_w) % hpc_w;
            res.head = quot[GEO_W-1:0];
            quot     = src.lba % spt_w + 1;
            res.sect = quot[GEO_W-1:0];
        end else begin
            acc     = LBA_W'(src.cyl) * hpc_w + LBA_W'(src.head);
            acc     = acc * spt_w + LBA_W'(src.sect) - 1;
            res.lba = acc;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result item against the oldest expected address
    always @(posedge i_clk) begin : result_monitor
        t_chs_addr got;
        t_chs_addr want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = m_axis_tdata;
            if (expected_addrs.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got 0x%0h", $time, got);
                mismatches++;
            end else begin
                want = expected_addrs.pop_front();
                check_field("lba_out", want.lba, got.lba);
                check_field("cylinder_out", 32'(want.cyl), 32'(got.cyl));
                check_field("head_out", 32'(want.head), 32'(got.head));
                check_field("sector_out", 32'(want.sect), 32'(got.sect));
                results_checked++;
            end
        end
    end

    // Stall the result side in random bursts, except in the quiet final phase
    initial begin : result_ready
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!quiet_run && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin : run_limit
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // One APB transfer; the leading edge keeps psel updates in separate steps
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_geometry_back(input logic [ADDR_W-1:0] addr, input logic [GEO_W-1:0] want);
        logic [DATA_W-1:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        check_field("prdata", DATA_W'(want), rdata);
    endtask

    // Drain the pipeline, then load and read back both geometry registers
    task automatic set_geometry(input logic [GEO_W-1:0] hpc, input logic [GEO_W-1:0] spt);
        logic [DATA_W-1:0] unused;
        s_axis_tvalid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
        apb_access(1'b1, HPC_ADDR, DATA_W'(hpc), unused);
        apb_access(1'b1, SPT_ADDR, DATA_W'(spt), unused);
        geo_hpc = hpc;
        geo_spt = spt;
        read_geometry_back(HPC_ADDR, hpc);
        read_geometry_back(SPT_ADDR, spt);
        geometries++;
    endtask

    // Random gap on the input side
    task automatic maybe_pause();
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Present one item, hold until accepted, then queue what it should produce
    task automatic send_item(input logic mode, input t_chs_addr addr, input bit typed,
                             input t_chs_addr want);
        s_axis_tuser  <= mode;
        s_axis_tdata  <= addr;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_addrs.push_back(typed ? want : translate_addr(mode, addr, geo_hpc, geo_spt));
        items_sent++;
    endtask

    task automatic add_row(input int hpc, input int spt,
                           input logic mode, input t_chs_addr addr, input int typed,
                           input t_chs_addr want);
        t_row row;
        row.hpc   = GEO_W'(hpc);
        row.spt   = GEO_W'(spt);
        row.mode  = mode;
        row.addr  = addr;
        row.typed = (typed != 0);
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    initial begin : stimulus
        t_chs_addr item;
        logic      mode;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_LBA2CHS;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        geo_hpc       = RESET_HPC;
        geo_spt       = RESET_SPT;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry must read back
        read_geometry_back(HPC_ADDR, RESET_HPC);
        read_geometry_back(SPT_ADDR, RESET_SPT);

        // Directed table: geometry, mode, {sector, head, cylinder, lba}, typed result
        add_row(16, 63, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'd0}, 1,
                {8'd1, 8'd0, 16'd0, 32'd0});
        add_row(16, 63, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'd1007}, 0, ALL_ZERO);
        add_row(16, 63, MODE_LBA2CHS, {8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF}, 0, ALL_ZERO);
        add_row(16, 63, MODE_CHS2LBA, {8'd1, 8'd0, 16'd0, 32'hFFFF_FFFF}, 1, ALL_ZERO);
        add_row(16, 63, MODE_CHS2LBA, {8'd0, 8'd0, 16'd0, 32'd0}, 1,
                {8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF});
        add_row(16, 63, MODE_CHS2LBA, {8'hFF, 8'hFF, 16'hFFFF, 32'd0}, 0, ALL_ZERO);
        add_row(16, 63, MODE_CHS2LBA, {8'd3, 8'd2, 16'd1, 32'd0}, 0, ALL_ZERO);
        add_row(16, 63, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'h5555_AAAA}, 0, ALL_ZERO);
        add_row(255, 255, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF}, 0, ALL_ZERO);
        add_row(255, 255, MODE_CHS2LBA, {8'hFF, 8'hFF, 16'hFFFF, 32'd0}, 0, ALL_ZERO);
        add_row(255, 255, MODE_CHS2LBA, {8'd0, 8'hFF, 16'hFFFF, 32'd0}, 0, ALL_ZERO);
        add_row(1, 1, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF}, 0, ALL_ZERO);
        add_row(1, 1, MODE_CHS2LBA, {8'd0, 8'hFF, 16'hFFFF, 32'd0}, 0, ALL_ZERO);
        add_row(0, 63, MODE_LBA2CHS, {8'd5, 8'd4, 16'd3, 32'd12345}, 1, ALL_ZERO);
        add_row(0, 63, MODE_CHS2LBA, {8'd5, 8'd4, 16'd3, 32'd12345}, 1, ALL_ZERO);
        add_row(16, 0, MODE_LBA2CHS, {8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF}, 1, ALL_ZERO);
        add_row(16, 0, MODE_CHS2LBA, {8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF}, 1, ALL_ZERO);
        add_row(0, 0, MODE_CHS2LBA, {8'hFF, 8'hFF, 16'hFFFF, 32'd0}, 1, ALL_ZERO);
        add_row(255, 1, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'h89AB_CDEF}, 0, ALL_ZERO);
        add_row(1, 255, MODE_LBA2CHS, {8'd0, 8'd0, 16'd0, 32'h00FF_FFFF}, 0, ALL_ZERO);
        add_row(2, 128, MODE_CHS2LBA, {8'h80, 8'h55, 16'hAAAA, 32'd0}, 0, ALL_ZERO);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].hpc != geo_hpc || directed_rows[i].spt != geo_spt) begin
                set_geometry(directed_rows[i].hpc, directed_rows[i].spt);
            end
            maybe_pause();
            send_item(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        // Random phases, one geometry each; extremes first, no idling in the last
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_geometry(8'd255, 8'd255);
                1: set_geometry(8'd1, 8'd1);
                2: set_geometry(8'd0, 8'($urandom_range(1, 255)));
                3: set_geometry(8'($urandom_range(1, 255)), 8'd0);
                4: set_geometry(8'd1, 8'd255);
                5: set_geometry(8'd255, 8'd1);
                default: set_geometry(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            endcase
            quiet_run = (p == RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                maybe_pause();
                mode     = 1'($urandom_range(0, 1));
                item.lba = $urandom;
                case ($urandom_range(0, 3))
                    1: item.lba = item.lba >> $urandom_range(0, 31);
                    2: item.lba = $urandom_range(0, 4095);
                    default: ;
                endcase
                item.cyl = 16'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    item.cyl = item.cyl >> $urandom_range(0, 15);
                end
                item.head = 8'($urandom);
                item.sect = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
                send_item(mode, item, 1'b0, ALL_ZERO);
            end
        end

        // Let every result come out, then watch for strays
        s_axis_tvalid <= 1'b0;
        while (expected_addrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items in both conversion directions across %0d geometry settings.",
                 items_sent, geometries);
        $display("Checked %0d results, covering zero geometry, sector wrap and cylinder truncation.",
                 results_checked);
        if (mismatches == 0 && expected_addrs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/chs_lba_pkg.sv
design/chs_lba_div_step.sv
design/chs_lba_pipe_ctrl.sv
design/chs_lba_translator_core.sv
dv/tb_top.sv
